>>> hdl/spread_crossfade_selector_unit_assert.svh
// Assertion macros shared by the selector's modules.
`ifndef SPREAD_CROSSFADE_SELECTOR_UNIT_ASSERT_SVH
`define SPREAD_CROSSFADE_SELECTOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SCSEL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scsel assertion failed");
`define SCSEL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scsel assertion failed");
`else
`define SCSEL_ASSERT(lbl, ante, cons)
`define SCSEL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/scsel_pkg.sv
package scsel_pkg;

  localparam int MAX_CHANNELS     = 512;
  localparam int SAMPLE_BITS      = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int COUNT_W    = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEXED_MODE  = 1'd1;
  localparam logic [COUNT_W-1:0]   CHANNEL_COUNT_RST = 10'd2;

  localparam int POS_W    = 32;
  localparam int SPREAD_W = 16;
  localparam int FRAC_W   = 16;
  localparam int N_W      = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W    = (COUNT_W > N_W) ? COUNT_W : N_W;
  localparam int CH_IDX_W = $clog2(MAX_CHANNELS);
  localparam int SPAN_W   = N_W + FRAC_W;
  localparam int FP_W     = SPAN_W + 1;
  localparam int MOD_STEPS = FP_W - FRAC_W - 1;
  localparam int MSH_W    = SPAN_W + MOD_STEPS - 1;
  localparam int PS_W     = POS_W + N_W + 1;

  localparam int SW_W      = SPREAD_W + 1;
  localparam int RECIP_W   = 24;
  localparam int DIV_STEPS = RECIP_W + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [SPREAD_W-1:0] SPREAD_MIN = 16'd26;

  localparam int LIM_W  = (SPAN_W > SW_W + 8) ? SPAN_W + 1 : SW_W + 9;
  localparam int XP_W   = SPAN_W + RECIP_W;
  localparam int X_W    = 16;
  localparam int GAIN_W = 16;
  localparam int TAB_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int ACC_W  = SAMPLE_BITS + GAIN_W - 1 + CH_IDX_W;
  localparam int RND_W  = ACC_W + 1;
  localparam int OUT_SH = GAIN_W - 1;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (OUT_SH - 1);
  localparam logic signed [RND_W-1:0] SAT_MAX  = RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_MIN  = ~SAT_MAX;

  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SCALE,
    FS_SETUP,
    FS_DIV,
    FS_PUSH
  } scsel_fstate_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_IDX_W-1:0]           chan;
    logic                          last;
    logic [SPAN_W-1:0]             fpm;
    logic [SW_W-1:0]               sw;
    logic [RECIP_W-1:0]            recip;
  } scsel_entry_t;

  typedef struct packed {
    logic avail;
    logic full;
  } scsel_qstat_t;

  function automatic logic [N_W-1:0] eff_count(input logic [COUNT_W-1:0] raw);
    logic [CMP_W-1:0] r;
    r = CMP_W'(raw);
    if (r < CMP_W'(2)) begin
      r = CMP_W'(2);
    end else if (r > CMP_W'(MAX_CHANNELS)) begin
      r = CMP_W'(MAX_CHANNELS);
    end
    return N_W'(r);
  endfunction

  function automatic logic [GAIN_W-1:0] sine_q15(input int unsigned k);
    longint unsigned kk;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned a;
    longint unsigned s;
    longint unsigned g;
    if (k <= SINE_TABLE_DEPTH - k) begin
      kk = 64'(k);
    end else begin
      kk = 64'(SINE_TABLE_DEPTH - k);
    end
    u  = (PI_Q30 * kk) / 64'(SINE_TABLE_DEPTH);
    u2 = (u * u) >> 30;
    a  = ONE_Q30 - u2 / 64'd72;
    a  = ONE_Q30 - ((u2 * a) >> 30) / 64'd42;
    a  = ONE_Q30 - ((u2 * a) >> 30) / 64'd20;
    a  = ONE_Q30 - ((u2 * a) >> 30) / 64'd6;
    s  = (u * a) >> 30;
    g  = (s + 64'd16384) >> 15;
    if (g > 64'd32768) begin
      g = 64'd32768;
    end
    return GAIN_W'(g);
  endfunction

endpackage

>>> hdl/scsel_queue.sv
`include "spread_crossfade_selector_unit_assert.svh"

module scsel_queue import scsel_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  scsel_entry_t entry_i,
  input  logic         pop_i,
  output scsel_entry_t entry_o,
  output scsel_qstat_t qstat_o
);

  scsel_entry_t    mem_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wp_r, wp_nxt;
  logic [QP_W-1:0] rp_r, rp_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (push_i) begin
      wp_nxt = (wp_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop_i) begin
      rp_nxt = (rp_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wp_r] <= entry_i;
    end
  end

  assign entry_o       = mem_r[rp_r];
  assign qstat_o.avail = (count_r != '0);
  assign qstat_o.full  = (count_r == QC_W'(QUEUE_DEPTH));

  `SCSEL_ASSERT(a_no_pop_empty, pop_i, count_r != '0)
  `SCSEL_ASSERT_NXT(a_count_step, push_i && !pop_i, count_r == $past(count_r) + 1'b1)

endmodule

>>> hdl/scsel_front.sv
`include "spread_crossfade_selector_unit_assert.svh"

module scsel_front import scsel_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_channel_sample,
  input  logic signed [POS_W-1:0]       in_position,
  input  logic [SPREAD_W-1:0]           in_spread,
  input  logic [N_W-1:0]                n_i,
  input  logic                          indexed_i,
  input  logic                          restart_i,
  input  scsel_qstat_t                  qstat_i,
  output logic                          push_o,
  output scsel_entry_t                  entry_o
);

  scsel_fstate_t                 state_r, state_nxt;
  logic [CH_IDX_W-1:0]           chan_r, chan_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic signed [POS_W-1:0]       pos_r, pos_nxt;
  logic [SPREAD_W-1:0]           spr_r, spr_nxt;
  logic signed [PS_W-1:0]        pscale_r, pscale_nxt;
  logic [FP_W-1:0]               rem_r, rem_nxt;
  logic [MSH_W-1:0]              msh_r, msh_nxt;
  logic [SW_W-1:0]               sw_r, sw_nxt;
  logic [SW_W-1:0]               dr_r, dr_nxt;
  logic [RECIP_W-1:0]            recip_r, recip_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  logic                   accept;
  logic                   last;
  logic [SPAN_W-1:0]      span;
  logic [SPAN_W-1:0]      pclamp;
  logic signed [PS_W-1:0] pmul;
  logic [SW_W:0]          dshift;

  assign span   = {n_i, {FRAC_W{1'b0}}};
  assign accept = in_valid && in_ready;
  assign last   = ((N_W + 1)'(chan_r) + 1'b1) >= (N_W + 1)'(n_i);
  assign pmul   = PS_W'(pos_r) * $signed(PS_W'({1'b0, n_i}));
  assign dshift = {dr_r, (cnt_r == '0)};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (accept && chan_r == '0) begin
          state_nxt = FS_SCALE;
        end
      end
      FS_SCALE: state_nxt = FS_SETUP;
      FS_SETUP: state_nxt = FS_DIV;
      FS_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!qstat_i.full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == FS_IDLE) && !qstat_i.full;
    push_o   = (accept && chan_r != '0) || (state_r == FS_PUSH && !qstat_i.full);
    entry_o.sample = (state_r == FS_PUSH) ? sample_r : in_channel_sample;
    entry_o.chan   = chan_r;
    entry_o.last   = last;
    entry_o.fpm    = rem_r[SPAN_W-1:0];
    entry_o.sw     = sw_r;
    entry_o.recip  = recip_r;
  end

  always_comb begin
    if (pscale_r[PS_W-1]) begin
      pclamp = '0;
    end else if (pscale_r > $signed(PS_W'(span))) begin
      pclamp = span;
    end else begin
      pclamp = pscale_r[SPAN_W-1:0];
    end
  end

  always_comb begin
    sample_nxt = sample_r;
    pos_nxt    = pos_r;
    spr_nxt    = spr_r;
    pscale_nxt = pscale_r;
    rem_nxt    = rem_r;
    msh_nxt    = msh_r;
    sw_nxt     = sw_r;
    dr_nxt     = dr_r;
    recip_nxt  = recip_r;
    cnt_nxt    = cnt_r;
    chan_nxt   = chan_r;
    if (accept && chan_r == '0) begin
      sample_nxt = in_channel_sample;
      pos_nxt    = in_position;
      spr_nxt    = (in_spread < SPREAD_MIN) ? SPREAD_MIN : in_spread;
    end
    case (state_r)
      FS_SCALE: begin
        pscale_nxt = indexed_i ? PS_W'(pos_r) : pmul;
      end
      FS_SETUP: begin
        rem_nxt   = FP_W'(pclamp) + FP_W'({spr_r, 8'h00});
        msh_nxt   = MSH_W'(span) << (MOD_STEPS - 1);
        sw_nxt    = {spr_r, 1'b0};
        dr_nxt    = '0;
        recip_nxt = '0;
        cnt_nxt   = '0;
      end
      FS_DIV: begin
        if (cnt_r < CNT_W'(MOD_STEPS)) begin
          if (MSH_W'(rem_r) >= msh_r) begin
            rem_nxt = FP_W'(MSH_W'(rem_r) - msh_r);
          end
          msh_nxt = msh_r >> 1;
        end
        if (dshift >= {1'b0, sw_r}) begin
          dr_nxt    = SW_W'(dshift - {1'b0, sw_r});
          recip_nxt = {recip_r[RECIP_W-2:0], 1'b1};
        end else begin
          dr_nxt    = dshift[SW_W-1:0];
          recip_nxt = {recip_r[RECIP_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      default: ;
    endcase
    if (push_o) begin
      chan_nxt = last ? '0 : chan_r + 1'b1;
    end
    if (restart_i) begin
      chan_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    pos_r    <= pos_nxt;
    spr_r    <= spr_nxt;
    pscale_r <= pscale_nxt;
    rem_r    <= rem_nxt;
    msh_r    <= msh_nxt;
    sw_r     <= sw_nxt;
    dr_r     <= dr_nxt;
    recip_r  <= recip_nxt;
    cnt_r    <= cnt_nxt;
  end

  `SCSEL_ASSERT(a_chan_range, 1'b1, (N_W + 1)'(chan_r) < (N_W + 1)'(n_i))
  `SCSEL_ASSERT(a_push_room, push_o, !qstat_i.full)
  `SCSEL_ASSERT_NXT(a_div_start, state_r == FS_SETUP, state_r == FS_DIV && cnt_r == '0)

endmodule

>>> hdl/scsel_back.sv
`include "spread_crossfade_selector_unit_assert.svh"

module scsel_back import scsel_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scsel_qstat_t                  qstat_i,
  input  scsel_entry_t                  entry_i,
  output logic                          pop_o,
  input  logic [N_W-1:0]                n_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_mix_sample
);

  logic [GAIN_W-1:0] sine_tab [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
    assign sine_tab[k] = sine_q15(k);
  end

  logic advance;

  logic                          v1_r, v2_r, v3_r, v4_r;
  logic [SPAN_W-1:0]             d1_r, d1_nxt;
  logic                          in1_r, in1_nxt;
  logic [RECIP_W-1:0]            recip1_r;
  logic signed [SAMPLE_BITS-1:0] smp1_r, smp2_r, smp3_r;
  logic                          first1_r, first2_r, first3_r, first4_r;
  logic                          last1_r, last2_r, last3_r, last4_r;
  logic [TAB_W-1:0]              idx2_r, idx2_nxt;
  logic                          in2_r;
  logic [GAIN_W-1:0]             gain3_r, gain3_nxt;
  logic signed [PROD_W-1:0]      prod4_r, prod4_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] mix_r, mix_nxt;

  logic [SPAN_W-1:0]       span;
  logic [SPAN_W:0]         wrap;
  logic [XP_W-1:0]         xprod;
  logic [X_W-1:0]          xfrac;
  logic signed [RND_W-1:0] rsum;
  logic signed [RND_W-1:0] rsh;

  assign span    = {n_i, {FRAC_W{1'b0}}};
  assign advance = !(out_valid_r && !out_ready);
  assign pop_o   = qstat_i.avail && advance;

  always_comb begin
    wrap = (SPAN_W + 1)'(entry_i.fpm) + (SPAN_W + 1)'(span)
         - (SPAN_W + 1)'({entry_i.chan, {FRAC_W{1'b0}}});
    if (wrap >= (SPAN_W + 1)'(span)) begin
      d1_nxt = SPAN_W'(wrap - (SPAN_W + 1)'(span));
    end else begin
      d1_nxt = wrap[SPAN_W-1:0];
    end
    in1_nxt = LIM_W'(d1_nxt) < LIM_W'({entry_i.sw, 8'h00});
  end

  assign xprod    = XP_W'(d1_r) * XP_W'(recip1_r);
  assign xfrac    = xprod[FRAC_W +: X_W];
  assign idx2_nxt = xfrac[X_W-1 -: TAB_W];

  assign gain3_nxt = in2_r ? sine_tab[idx2_r] : '0;
  assign prod4_nxt = $signed(PROD_W'(smp3_r)) * $signed(PROD_W'({1'b0, gain3_r}));

  always_comb begin
    acc_nxt = (first4_r ? '0 : acc_r) + ACC_W'(prod4_r);
    rsum    = RND_W'(acc_nxt) + RND_HALF;
    rsh     = rsum >>> OUT_SH;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    mix_nxt       = mix_r;
    if (advance && v4_r && last4_r) begin
      out_valid_nxt = 1'b1;
      if (rsh > SAT_MAX) begin
        mix_nxt = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (rsh < SAT_MIN) begin
        mix_nxt = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
        mix_nxt = rsh[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        v1_r <= pop_o;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d1_r     <= d1_nxt;
      in1_r    <= in1_nxt;
      recip1_r <= entry_i.recip;
      smp1_r   <= entry_i.sample;
      first1_r <= (entry_i.chan == '0);
      last1_r  <= entry_i.last;
      idx2_r   <= idx2_nxt;
      in2_r    <= in1_r;
      smp2_r   <= smp1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      gain3_r  <= gain3_nxt;
      smp3_r   <= smp2_r;
      first3_r <= first2_r;
      last3_r  <= last2_r;
      prod4_r  <= prod4_nxt;
      first4_r <= first3_r;
      last4_r  <= last3_r;
      if (v4_r) begin
        acc_r <= acc_nxt;
      end
    end
    mix_r <= mix_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_mix_sample = mix_r;

  `SCSEL_ASSERT_NXT(a_out_from_last, !out_valid_r, !out_valid_r || $past(v4_r && last4_r))

endmodule

>>> hdl/spread_crossfade_selector_unit.sv
// Channel 0 item: the front runs scale, setup, 25-step reciprocal divide with modulo, push.
// Channels 1..N-1: one item per cycle while the queue is not full.
// mix_sample is registered once the last channel's item has passed the queue and the mix stages.
// A two-entry queue parts the front from the five-stage mix pipeline.
// Reset: rst_n synchronous, active low; channel_count 2, indexed_mode 0, frame at channel 0.
module spread_crossfade_selector_unit import scsel_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_channel_sample,
  input  logic signed [POS_W-1:0]       in_position,
  input  logic [SPREAD_W-1:0]           in_spread,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_mix_sample,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               indexed_r, indexed_nxt;
  logic               restart;
  logic [N_W-1:0]     n_eff;

  logic         push;
  logic         pop;
  scsel_entry_t push_entry;
  scsel_entry_t head_entry;
  scsel_qstat_t qstat;

  always_comb begin
    count_nxt   = count_r;
    indexed_nxt = indexed_r;
    restart     = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: begin
          count_nxt = COUNT_W'(cfg_wdata);
          restart   = 1'b1;
        end
        REG_INDEXED_MODE: indexed_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= CHANNEL_COUNT_RST;
      indexed_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      indexed_r <= indexed_nxt;
    end
  end

  assign n_eff = eff_count(count_r);

  scsel_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel_sample (in_channel_sample),
    .in_position       (in_position),
    .in_spread         (in_spread),
    .n_i               (n_eff),
    .indexed_i         (indexed_r),
    .restart_i         (restart),
    .qstat_i           (qstat),
    .push_o            (push),
    .entry_o           (push_entry)
  );

  scsel_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  scsel_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qstat_i        (qstat),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .n_i            (n_eff),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mix_sample (out_mix_sample)
  );

endmodule

>>> bench/spread_crossfade_selector_unit_test.sv
`timescale 1ns / 100ps

module spread_crossfade_selector_unit_test;
  import scsel_pkg::*;

  localparam int ITEM_GOAL = 1350;
  localparam int IDLE_GAP = 120;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int CALM_ITEMS = 150;
  localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
  localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
  localparam longint SPREAD_FLOOR = 26;
  localparam int LUT_DEPTH = 256;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] smp;
    logic [POS_W-1:0]       pos;
    logic [SPREAD_W-1:0]    spr;
    logic                   known;
    logic [SAMPLE_BITS-1:0] mix;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_BITS-1:0] in_channel_sample = '0;
  logic signed [POS_W-1:0] in_position = '0;
  logic [SPREAD_W-1:0] in_spread = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_mix_sample;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [CFG_DATA_W-1:0] chan_count_raw;
  logic unit_mode;
  logic [8:0] next_chan;
  logic [31:0] frame_pos;
  logic [16:0] fade_width;
  logic [23:0] fade_recip;
  logic signed [39:0] mix_acc;
  logic [15:0] sine_lut [LUT_DEPTH];

  logic signed [SAMPLE_BITS-1:0] mix_pending [$];
  logic signed [SAMPLE_BITS-1:0] mix_want;
  int mix_errors = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit squeeze_out = 1'b0;

  probe_row_t probe_rows [16] = '{
    '{16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
    '{16'h0000, 32'h8000_0000, 16'hFFFF, 1'b1, 16'h0000},
    '{16'h7FFF, 32'h0000_0000, 16'h0100, 1'b0, 16'h0000},
    '{16'h8000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 16'h7FFF},
    '{16'h8000, 32'h0000_0000, 16'h0100, 1'b0, 16'h0000},
    '{16'h7FFF, 32'hFFFF_FFFF, 16'h00FF, 1'b1, 16'h8000},
    '{16'h5555, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{16'hAAAA, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
    '{16'h8000, 32'h8000_0000, 16'd25,   1'b0, 16'h0000},
    '{16'h8000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{16'h7FFF, 32'h0000_8000, 16'd26,   1'b0, 16'h0000},
    '{16'h7FFF, 32'h1234_5678, 16'h8000, 1'b0, 16'h0000},
    '{16'h0001, 32'h0001_0000, 16'h0080, 1'b0, 16'h0000},
    '{16'hFFFF, 32'hFFFF_0000, 16'h0001, 1'b0, 16'h0000},
    '{16'h3039, 32'h0000_C000, 16'h0200, 1'b0, 16'h0000},
    '{16'hCFC7, 32'h0000_4000, 16'h7FFF, 1'b0, 16'h0000}
  };

  spread_crossfade_selector_unit DUT (.*);

  always #4 clk = ~clk;

  function automatic void fill_sine_lut();
    longint unsigned m;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned a;
    longint unsigned s;
    longint unsigned g;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      m = (k <= LUT_DEPTH - k) ? k : LUT_DEPTH - k;
      u = (HALF_TURN_Q30 * m) / LUT_DEPTH;
      u2 = (u * u) >> 30;
      a = UNIT_Q30 - u2 / 72;
      a = UNIT_Q30 - ((u2 * a) >> 30) / 42;
      a = UNIT_Q30 - ((u2 * a) >> 30) / 20;
      a = UNIT_Q30 - ((u2 * a) >> 30) / 6;
      s = (u * a) >> 30;
      g = (s + 16384) >> 15;
      if (g > 32768) begin
        g = 32768;
      end
      sine_lut[k] = 16'(g);
    end
  endfunction

  function automatic int live_channels();
    int n;
    n = chan_count_raw;
    if (n < 2) begin
      n = 2;
    end else if (n > MAX_CHANNELS) begin
      n = MAX_CHANNELS;
    end
    return n;
  endfunction

  function automatic void step_mixer(input logic signed [SAMPLE_BITS-1:0] smp,
                                     input logic [POS_W-1:0] pos,
                                     input logic [SPREAD_W-1:0] spr,
                                     output bit emits,
                                     output logic signed [SAMPLE_BITS-1:0] mix);
    longint n;
    longint span;
    longint p;
    longint s;
    longint d;
    longint x;
    longint k;
    longint gain;
    longint sum;
    longint r;
    n = live_channels();
    span = n << 16;
    emits = 1'b0;
    mix = '0;
    if (next_chan >= n) begin
      next_chan = '0;
    end
    if (next_chan == 0) begin
      p = $signed(pos);
      s = spr;
      if (s < SPREAD_FLOOR) begin
        s = SPREAD_FLOOR;
      end
      fade_width = 17'(s * 2);
      fade_recip = 24'((longint'(1) << 24) / (s * 2));
      if (!unit_mode) begin
        p = p * n;
      end
      if (p < 0) begin
        p = 0;
      end else if (p > span) begin
        p = span;
      end
      frame_pos = 32'(p + (s << 8));
      mix_acc = '0;
    end
    d = (longint'(frame_pos) + span - (longint'(next_chan) << 16)) % span;
    gain = 0;
    if (d < (longint'(fade_width) << 8)) begin
      x = (d * longint'(fade_recip)) >> 16;
      k = (x * LUT_DEPTH) >> 16;
      if (k >= LUT_DEPTH) begin
        k = LUT_DEPTH - 1;
      end
      gain = sine_lut[k];
    end
    sum = longint'(mix_acc) + longint'(smp) * gain;
    mix_acc = 40'(sum);
    if (longint'(next_chan) + 1 >= n) begin
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end else if (r < -32768) begin
        r = -32768;
      end
      mix = SAMPLE_BITS'(r);
      emits = 1'b1;
      next_chan = '0;
      mix_acc = '0;
    end else begin
      next_chan = next_chan + 1'b1;
    end
  endfunction

  task automatic offer_item(input logic signed [SAMPLE_BITS-1:0] smp,
                            input logic [POS_W-1:0] pos,
                            input logic [SPREAD_W-1:0] spr,
                            input logic known,
                            input logic signed [SAMPLE_BITS-1:0] known_mix);
    bit emits;
    logic signed [SAMPLE_BITS-1:0] mix;
    in_valid <= 1'b1;
    in_channel_sample <= smp;
    in_position <= pos;
    in_spread <= spr;
    do @(posedge clk); while (!in_ready);
    step_mixer(smp, pos, spr, emits, mix);
    if (emits) begin
      mix_pending.push_back(known ? known_mix : mix);
    end
    items_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_mixer();
    in_valid <= 1'b0;
    while (mix_pending.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_CHANNEL_COUNT) begin
      chan_count_raw = val;
      next_chan = '0;
      mix_acc = '0;
    end else if (idx == REG_INDEXED_MODE) begin
      unit_mode = val[0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic play_frames(input int frames, input int partial);
    int n;
    int total;
    int j;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [POS_W-1:0] pos;
    logic [SPREAD_W-1:0] spr;
    n = live_channels();
    total = frames * n + partial;
    for (int i = 0; i < total; i++) begin
      j = i % n;
      case ($urandom_range(0, 7))
        0: smp = 16'h7FFF;
        1: smp = 16'h8000;
        default: smp = $urandom;
      endcase
      pos = $urandom;
      spr = $urandom;
      if (j == 0) begin
        case ($urandom_range(0, 9))
          0: ;
          1: pos = -$urandom_range(1, 65536);
          2: pos = unit_mode ? (n << 16) + $urandom_range(0, 65536)
                             : 32'h0001_0000 + $urandom_range(0, 65536);
          default: pos = unit_mode ? $urandom_range(0, n << 16) : $urandom_range(0, 65536);
        endcase
        case ($urandom_range(0, 5))
          0: ;
          1: spr = $urandom_range(0, 26);
          default: spr = $urandom_range(26, (n * 256 > 65535) ? 65535 : n * 256);
        endcase
      end
      offer_item(smp, pos, spr, 1'b0, '0);
    end
  endtask

  initial begin
    int phase;
    int cnt;
    int n;
    int partial;
    logic [CFG_DATA_W-1:0] mode_word;
    fill_sine_lut();
    chan_count_raw = CFG_DATA_W'(CHANNEL_COUNT_RST);
    unit_mode = 1'b0;
    next_chan = '0;
    frame_pos = '0;
    fade_width = '0;
    fade_recip = '0;
    mix_acc = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_rows[i]) begin
      offer_item(probe_rows[i].smp, probe_rows[i].pos, probe_rows[i].spr,
                 probe_rows[i].known, probe_rows[i].mix);
    end
    drain_mixer();

    set_reg(REG_CHANNEL_COUNT, 10'd0);
    set_reg(REG_INDEXED_MODE, 10'd1);
    play_frames(10, 0);
    drain_mixer();

    set_reg(REG_CHANNEL_COUNT, 10'd5);
    set_reg(REG_INDEXED_MODE, 10'd0);
    play_frames(0, 3);
    drain_mixer();
    set_reg(REG_CHANNEL_COUNT, 10'd1);
    set_reg(REG_INDEXED_MODE, 10'h3FE);
    play_frames(10, 0);
    drain_mixer();

    set_reg(REG_CHANNEL_COUNT, 10'd512);
    set_reg(REG_INDEXED_MODE, 10'd1);
    play_frames(0, 4);
    drain_mixer();
    set_reg(REG_CHANNEL_COUNT, 10'h3FF);
    set_reg(REG_INDEXED_MODE, 10'h200);
    play_frames(1, 0);
    drain_mixer();

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      if (items_sent > ITEM_GOAL - CALM_ITEMS) begin
        calm = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: cnt = $urandom_range(0, 1);
        1, 2: cnt = $urandom_range(9, 40);
        default: cnt = $urandom_range(2, 8);
      endcase
      if (phase == 1) begin
        cnt = 3;
      end
      mode_word = $urandom;
      set_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(cnt));
      set_reg(REG_INDEXED_MODE, mode_word);
      n = live_channels();
      partial = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : 0;
      if (phase == 1) begin
        squeeze_out = 1'b1;
        play_frames(16, 0);
      end else begin
        play_frames($urandom_range(4, 12), partial);
      end
      drain_mixer();
      phase++;
    end

    if (mix_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (squeeze_out) begin
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_out = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mix_pending.size() == 0) begin
        $error("mix_sample: expected none, got %0d", out_mix_sample);
        mix_errors++;
      end else begin
        mix_want = mix_pending.pop_front();
        if (out_mix_sample !== mix_want) begin
          $error("mix_sample: expected %0d, got %0d", mix_want, out_mix_sample);
          mix_errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/scsel_pkg.sv
hdl/scsel_queue.sv
hdl/scsel_front.sv
hdl/scsel_back.sv
hdl/spread_crossfade_selector_unit.sv
bench/spread_crossfade_selector_unit_test.sv
